@@ hw/rtl/cpbb_pkg.sv @@
// shared constants, payload types and unit op codes for the cubic path bounding box
// no dependencies
package cpbb_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int T_BITS      = 60 - COORD_WIDTH;
	localparam int COEF_WIDTH  = COORD_WIDTH + 4;
	localparam int MAG_WIDTH   = COORD_WIDTH + 3;
	localparam int WIDE_WIDTH  = 2 * MAG_WIDTH;
	localparam int TQ_WIDTH    = T_BITS + 1;
	localparam int PROD_WIDTH  = COORD_WIDTH + TQ_WIDTH;

	localparam logic [1:0] KIND_CURVE = 2'd2;

	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_SQRT = 2'd1;
	localparam logic [1:0] OP_DIV  = 2'd2;
	localparam logic [1:0] OP_LERP = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic [1:0] kind;
		coord_t     x_coord;
		coord_t     y_coord;
		logic       last;
	} item_t;

	typedef struct packed {
		coord_t                 left;
		coord_t                 top;
		logic [COORD_WIDTH-1:0] width;
		logic [COORD_WIDTH-1:0] height;
	} box_t;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} unit_cmd_t;

endpackage

@@ hw/rtl/cpbb_unit.sv @@
// shared iterative arithmetic unit: serial multiply, square root, divide, lerp
// depends on cpbb_pkg
module cpbb_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cpbb_pkg::unit_cmd_t                   cmd,
	input  logic [cpbb_pkg::WIDE_WIDTH-1:0]       arg_wide,
	input  logic [cpbb_pkg::MAG_WIDTH-1:0]        arg_mag_a,
	input  logic [cpbb_pkg::MAG_WIDTH-1:0]        arg_mag_b,
	input  cpbb_pkg::coord_t                      lerp_a,
	input  cpbb_pkg::coord_t                      lerp_b,
	input  logic [cpbb_pkg::TQ_WIDTH-1:0]         tq,
	output logic                                  done,
	output logic [cpbb_pkg::WIDE_WIDTH-1:0]       res
);

	localparam int W     = cpbb_pkg::COORD_WIDTH;
	localparam int T     = cpbb_pkg::T_BITS;
	localparam int MW    = cpbb_pkg::MAG_WIDTH;
	localparam int DW    = cpbb_pkg::WIDE_WIDTH;
	localparam int QW    = cpbb_pkg::TQ_WIDTH;
	localparam int PW    = cpbb_pkg::PROD_WIDTH;
	localparam int RW    = MW + 2;
	localparam int NW    = MW + QW;
	localparam int MAXIT = (MW > QW) ? MW : QW;
	localparam int CNT_W = $clog2(MAXIT + 1);
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (T - 1);

	logic [1:0]       op_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DW-1:0]    acc_q;
	logic [DW-1:0]    sh_q;
	logic [MW-1:0]    mb_q;
	logic [RW-1:0]    rem_q;
	logic [MW-1:0]    root_q;
	logic [QW-1:0]    low_q;
	logic [QW-1:0]    tq_q;
	logic [PW-1:0]    prod_q;
	logic [W-1:0]     la_q;
	logic             neg_q;
	logic [DW-1:0]    res_q;

	logic             fin;
	logic [DW-1:0]    acc_nx;
	logic [RW+1:0]    rem2;
	logic [RW+1:0]    trial;
	logic             sq_ge;
	logic [RW+1:0]    rem_s;
	logic [MW-1:0]    root_s;
	logic [MW:0]      r2;
	logic             d_ge;
	logic [MW:0]      rem_d;
	logic [QW-1:0]    low_d;
	logic [NW-1:0]    num;
	logic [W:0]       ldiff;
	logic [W:0]       lmag;
	logic [PW-1:0]    prod_c;
	logic [PW:0]      rnd;
	logic [PW:0]      rsh;
	logic [W-1:0]     res_l;

	assign fin = busy_q && (cnt_q == CNT_W'(1));

	always_comb begin
		acc_nx = mb_q[0] ? acc_q + sh_q : acc_q;
		rem2   = {rem_q, sh_q[DW-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		sq_ge  = rem2 >= trial;
		rem_s  = sq_ge ? rem2 - trial : rem2;
		root_s = {root_q[MW-2:0], sq_ge};
		r2     = {rem_q[MW-1:0], low_q[QW-1]};
		d_ge   = r2 >= {1'b0, mb_q};
		rem_d  = d_ge ? r2 - {1'b0, mb_q} : r2;
		low_d  = {low_q[QW-2:0], d_ge};
		num    = (NW'(arg_mag_a) << T) + NW'(arg_mag_b >> 1);
		ldiff  = {lerp_b[W-1], lerp_b} - {lerp_a[W-1], lerp_a};
		lmag   = ldiff[W] ? -ldiff : ldiff;
		prod_c = PW'(mb_q[W-1:0]) * PW'(tq_q);
		rnd    = {1'b0, prod_q} + HALF;
		rsh    = rnd >> T;
		res_l  = neg_q ? la_q - rsh[W-1:0] : la_q + rsh[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= cpbb_pkg::OP_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q   <= cmd.op;
				busy_q <= 1'b1;
				case (cmd.op)
					cpbb_pkg::OP_MUL:  cnt_q <= CNT_W'(MW);
					cpbb_pkg::OP_SQRT: cnt_q <= CNT_W'(MW);
					cpbb_pkg::OP_DIV:  cnt_q <= CNT_W'(QW);
					default:           cnt_q <= CNT_W'(2);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (fin) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			case (cmd.op)
				cpbb_pkg::OP_MUL: begin
					acc_q <= '0;
					sh_q  <= DW'(arg_mag_a);
					mb_q  <= arg_mag_b;
				end
				cpbb_pkg::OP_SQRT: begin
					sh_q   <= arg_wide;
					rem_q  <= '0;
					root_q <= '0;
				end
				cpbb_pkg::OP_DIV: begin
					rem_q <= RW'(num[NW-1:QW]);
					low_q <= num[QW-1:0];
					mb_q  <= arg_mag_b;
				end
				default: begin
					la_q  <= lerp_a;
					neg_q <= ldiff[W];
					mb_q  <= MW'(lmag[W-1:0]);
					tq_q  <= tq;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				cpbb_pkg::OP_MUL: begin
					acc_q <= acc_nx;
					sh_q  <= sh_q << 1;
					mb_q  <= mb_q >> 1;
					if (fin) begin
						res_q <= acc_nx;
					end
				end
				cpbb_pkg::OP_SQRT: begin
					rem_q  <= rem_s[RW-1:0];
					root_q <= root_s;
					sh_q   <= sh_q << 2;
					if (fin) begin
						res_q <= DW'(root_s);
					end
				end
				cpbb_pkg::OP_DIV: begin
					rem_q <= RW'(rem_d[MW-1:0]);
					low_q <= low_d;
					if (fin) begin
						res_q <= DW'(low_d);
					end
				end
				default: begin
					if (cnt_q == CNT_W'(2)) begin
						prod_q <= prod_c;
					end
					if (fin) begin
						res_q <= DW'(res_l);
					end
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ hw/rtl/cubic_path_bounding_box.sv @@
// top level: path element intake, running box, curve extrema sequencer
// depends on cpbb_pkg and cpbb_unit
//
//  channel  dir  handshake                payload
//  item     in   item_valid / item_ready  cpbb_pkg::item_t (kind, x_coord, y_coord, last)
//  box      out  box_valid / box_ready    cpbb_pkg::box_t (left, top, width, height)
//
// move, line, curve control and second curve point items leave the block in idle unless they end a path
// a curve end point holds the block for its extrema search: per axis, at most two serial multiplies,
// a square root, and a divide and 12 lerps per root, all run on cpbb_unit
// the last item of a path runs the flush states and the emit state before the box is loaded into the output register
// item_ready is low while a curve or a path end is in work; a box not yet taken stalls the next
// path end only; arst_n clears control, the running min and max load on the first item of a path
module cubic_path_bounding_box (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  cpbb_pkg::item_t  item,
	output logic             box_valid,
	input  logic             box_ready,
	output cpbb_pkg::box_t   box
);

	localparam int W  = cpbb_pkg::COORD_WIDTH;
	localparam int CW = cpbb_pkg::COEF_WIDTH;
	localparam int MW = cpbb_pkg::MAG_WIDTH;
	localparam int DW = cpbb_pkg::WIDE_WIDTH;
	localparam int QW = cpbb_pkg::TQ_WIDTH;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_COEF   = 4'd1;
	localparam logic [3:0] ST_CLASS  = 4'd2;
	localparam logic [3:0] ST_MUL1   = 4'd3;
	localparam logic [3:0] ST_MUL2   = 4'd4;
	localparam logic [3:0] ST_DISC   = 4'd5;
	localparam logic [3:0] ST_SQRT   = 4'd6;
	localparam logic [3:0] ST_TRY    = 4'd7;
	localparam logic [3:0] ST_DIV    = 4'd8;
	localparam logic [3:0] ST_LERP   = 4'd9;
	localparam logic [3:0] ST_LWAIT  = 4'd10;
	localparam logic [3:0] ST_ROOTNX = 4'd11;
	localparam logic [3:0] ST_NEXTAX = 4'd12;
	localparam logic [3:0] ST_FLUSH  = 4'd13;
	localparam logic [3:0] ST_EMIT   = 4'd14;

	localparam logic [3:0] LAST_STEP = 4'd9;
	localparam logic [8:0] STEP_SKIP = 9'b0_1100_1000;

	function automatic logic [MW-1:0] mag_of(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		t = v[CW-1] ? -v : v;
		return t[MW-1:0];
	endfunction

	logic [3:0]  state_q;
	logic        started_q;
	logic [1:0]  phase_q;
	logic        last_q;
	logic        flush_q;
	logic        axis_q;
	logic        ridx_q;
	logic        two_q;
	logic        csel_q;
	logic [3:0]  step_q;
	logic        box_valid_q;

	cpbb_pkg::coord_t prev_x_q, prev_y_q, cs_x_q, cs_y_q, fc_x_q, fc_y_q;
	cpbb_pkg::coord_t sc_x_q, sc_y_q, ep_x_q, ep_y_q;
	cpbb_pkg::coord_t min_x_q, max_x_q, min_y_q, max_y_q;
	cpbb_pkg::coord_t ln0_q, ln1_q, ln2_q, ln3_q, vx_q;
	logic signed [CW-1:0] ca_q, cb_q, cc_q, nn_q, dd_q;
	logic [DW-1:0] bsq_q, ac_q;
	logic [MW-1:0] s_q;
	logic [QW-1:0] tq_q;
	cpbb_pkg::box_t box_q;

	cpbb_pkg::unit_cmd_t cmd;
	logic [DW-1:0]       arg_wide;
	logic [MW-1:0]       arg_mag_a, arg_mag_b;
	logic                u_done;
	logic [DW-1:0]       u_res;

	logic accept, take_sc, take_end, take_ctrl, take_plain;
	cpbb_pkg::coord_t p0, p1, p2, p3, new_lane;
	logic signed [CW-1:0] e0, e1, e2, e3, a_c, b_c, c_c, s_ext, s_now;
	logic neg_ac, ac_le, disc_ok, nz, sign_bad, try_ok, coord_done, step_skip, emit_go;
	logic [MW-1:0] un, ud;
	logic box_set, inc_en;
	cpbb_pkg::coord_t inc_x, inc_y;

	assign accept     = item_valid && item_ready;
	assign take_sc    = started_q && phase_q == 2'd1;
	assign take_end   = started_q && phase_q == 2'd2;
	assign take_ctrl  = started_q && phase_q == 2'd0 && item.kind == cpbb_pkg::KIND_CURVE;
	assign take_plain = started_q && phase_q == 2'd0 && item.kind != cpbb_pkg::KIND_CURVE;
	assign box_set    = accept && !started_q;
	assign emit_go    = state_q == ST_EMIT && (!box_valid_q || box_ready);
	assign coord_done = step_q == LAST_STEP;
	assign step_skip  = STEP_SKIP[step_q];

	always_comb begin
		p0 = axis_q ? cs_y_q : cs_x_q;
		p1 = axis_q ? fc_y_q : fc_x_q;
		p2 = axis_q ? sc_y_q : sc_x_q;
		p3 = axis_q ? ep_y_q : ep_x_q;
		e0 = CW'(p0);
		e1 = CW'(p1);
		e2 = CW'(p2);
		e3 = CW'(p3);
		a_c = (e3 - e0) + (e1 - e2) + ((e1 - e2) <<< 1);
		b_c = e0 - (e1 <<< 1) + e2;
		c_c = e1 - e0;
		s_ext = $signed({1'b0, s_q});
		s_now = $signed({1'b0, u_res[MW-1:0]});
		neg_ac  = cc_q != '0 && (ca_q[CW-1] != cc_q[CW-1]);
		ac_le   = ac_q <= bsq_q;
		disc_ok = neg_ac || ac_le;
		arg_wide = neg_ac ? bsq_q + ac_q : bsq_q - ac_q;
		un = mag_of(nn_q);
		ud = mag_of(dd_q);
		nz = nn_q != '0;
		sign_bad = nz && (nn_q[CW-1] != dd_q[CW-1]);
		try_ok = dd_q != '0 && !sign_bad && un <= ud;
		new_lane = u_res[W-1:0];
	end

	always_comb begin
		cmd.start = 1'b0;
		cmd.op    = cpbb_pkg::OP_MUL;
		arg_mag_a = un;
		arg_mag_b = ud;
		case (state_q)
			ST_CLASS: begin
				arg_mag_a = mag_of(cb_q);
				arg_mag_b = mag_of(cb_q);
				cmd.start = ca_q != '0;
			end
			ST_MUL1: begin
				arg_mag_a = mag_of(ca_q);
				arg_mag_b = mag_of(cc_q);
				cmd.start = u_done;
			end
			ST_DISC: begin
				cmd.start = disc_ok;
				cmd.op    = cpbb_pkg::OP_SQRT;
			end
			ST_TRY: begin
				cmd.start = try_ok;
				cmd.op    = cpbb_pkg::OP_DIV;
			end
			ST_LERP: begin
				cmd.start = !coord_done && !step_skip;
				cmd.op    = cpbb_pkg::OP_LERP;
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		inc_en = 1'b0;
		inc_x  = item.x_coord;
		inc_y  = item.y_coord;
		case (state_q)
			ST_IDLE: begin
				inc_en = accept && (take_end || take_plain);
			end
			ST_FLUSH: begin
				if (!flush_q) begin
					inc_en = phase_q != 2'd0;
					inc_x  = fc_x_q;
					inc_y  = fc_y_q;
				end else begin
					inc_en = phase_q == 2'd2;
					inc_x  = sc_x_q;
					inc_y  = sc_y_q;
				end
			end
			ST_LERP: begin
				inc_en = coord_done && csel_q;
				inc_x  = vx_q;
				inc_y  = ln3_q;
			end
			default: begin
				inc_en = 1'b0;
			end
		endcase
	end

	cpbb_unit u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.arg_wide  (arg_wide),
		.arg_mag_a (arg_mag_a),
		.arg_mag_b (arg_mag_b),
		.lerp_a    (ln0_q),
		.lerp_b    (ln1_q),
		.tq        (tq_q),
		.done      (u_done),
		.res       (u_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			phase_q     <= 2'd0;
			last_q      <= 1'b0;
			flush_q     <= 1'b0;
			axis_q      <= 1'b0;
			ridx_q      <= 1'b0;
			two_q       <= 1'b0;
			csel_q      <= 1'b0;
			step_q      <= '0;
			box_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				box_valid_q <= 1'b1;
			end else if (box_ready) begin
				box_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= item.last;
						if (!started_q) begin
							started_q <= 1'b1;
						end else if (take_sc) begin
							phase_q <= 2'd2;
						end else if (take_end) begin
							phase_q <= 2'd0;
						end else if (take_ctrl) begin
							phase_q <= 2'd1;
						end
						if (take_end) begin
							axis_q  <= 1'b0;
							state_q <= ST_COEF;
						end else if (item.last) begin
							flush_q <= 1'b0;
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_COEF: state_q <= ST_CLASS;
				ST_CLASS: begin
					if (ca_q != '0) begin
						state_q <= ST_MUL1;
					end else if (cb_q != '0) begin
						ridx_q  <= 1'b0;
						two_q   <= 1'b0;
						state_q <= ST_TRY;
					end else begin
						state_q <= ST_NEXTAX;
					end
				end
				ST_MUL1: begin
					if (u_done) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (u_done) begin
						state_q <= ST_DISC;
					end
				end
				ST_DISC: state_q <= disc_ok ? ST_SQRT : ST_NEXTAX;
				ST_SQRT: begin
					if (u_done) begin
						ridx_q  <= 1'b0;
						two_q   <= 1'b1;
						state_q <= ST_TRY;
					end
				end
				ST_TRY: state_q <= try_ok ? ST_DIV : ST_ROOTNX;
				ST_DIV: begin
					if (u_done) begin
						csel_q  <= 1'b0;
						step_q  <= '0;
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					if (coord_done) begin
						if (!csel_q) begin
							csel_q <= 1'b1;
							step_q <= '0;
						end else begin
							state_q <= ST_ROOTNX;
						end
					end else if (step_skip) begin
						step_q <= step_q + 4'd1;
					end else begin
						state_q <= ST_LWAIT;
					end
				end
				ST_LWAIT: begin
					if (u_done) begin
						step_q  <= step_q + 4'd1;
						state_q <= ST_LERP;
					end
				end
				ST_ROOTNX: begin
					if (two_q && !ridx_q) begin
						ridx_q  <= 1'b1;
						state_q <= ST_TRY;
					end else begin
						state_q <= ST_NEXTAX;
					end
				end
				ST_NEXTAX: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_COEF;
					end else if (last_q) begin
						flush_q <= 1'b0;
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (!flush_q) begin
						flush_q <= 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						started_q <= 1'b0;
						phase_q   <= 2'd0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					prev_x_q <= item.x_coord;
					prev_y_q <= item.y_coord;
					if (take_sc) begin
						sc_x_q <= item.x_coord;
						sc_y_q <= item.y_coord;
					end
					if (take_end) begin
						ep_x_q <= item.x_coord;
						ep_y_q <= item.y_coord;
					end
					if (take_ctrl) begin
						cs_x_q <= prev_x_q;
						cs_y_q <= prev_y_q;
						fc_x_q <= item.x_coord;
						fc_y_q <= item.y_coord;
					end
				end
			end
			ST_COEF: begin
				ca_q <= a_c;
				cb_q <= b_c;
				cc_q <= c_c;
			end
			ST_CLASS: begin
				nn_q <= -cc_q;
				dd_q <= cb_q <<< 1;
			end
			ST_MUL1: begin
				if (u_done) begin
					bsq_q <= u_res;
				end
			end
			ST_MUL2: begin
				if (u_done) begin
					ac_q <= u_res;
				end
			end
			ST_SQRT: begin
				if (u_done) begin
					s_q  <= u_res[MW-1:0];
					nn_q <= s_now - cb_q;
					dd_q <= ca_q;
				end
			end
			ST_DIV: begin
				if (u_done) begin
					tq_q  <= u_res[QW-1:0];
					ln0_q <= cs_x_q;
					ln1_q <= fc_x_q;
					ln2_q <= sc_x_q;
					ln3_q <= ep_x_q;
				end
			end
			ST_LERP: begin
				if (coord_done) begin
					if (!csel_q) begin
						vx_q  <= ln3_q;
						ln0_q <= cs_y_q;
						ln1_q <= fc_y_q;
						ln2_q <= sc_y_q;
						ln3_q <= ep_y_q;
					end
				end else if (step_skip) begin
					ln0_q <= ln1_q;
					ln1_q <= ln2_q;
					ln2_q <= ln3_q;
				end
			end
			ST_LWAIT: begin
				if (u_done) begin
					ln0_q <= ln1_q;
					ln1_q <= ln2_q;
					ln2_q <= ln3_q;
					ln3_q <= new_lane;
				end
			end
			ST_ROOTNX: begin
				nn_q <= -cb_q - s_ext;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (box_set) begin
			min_x_q <= item.x_coord;
			max_x_q <= item.x_coord;
			min_y_q <= item.y_coord;
			max_y_q <= item.y_coord;
		end else if (inc_en) begin
			if (inc_x < min_x_q) min_x_q <= inc_x;
			if (inc_x > max_x_q) max_x_q <= inc_x;
			if (inc_y < min_y_q) min_y_q <= inc_y;
			if (inc_y > max_y_q) max_y_q <= inc_y;
		end
		if (emit_go) begin
			box_q.left   <= min_x_q;
			box_q.top    <= min_y_q;
			box_q.width  <= max_x_q - min_x_q;
			box_q.height <= max_y_q - min_y_q;
		end
	end

	assign item_ready = state_q == ST_IDLE;
	assign box_valid  = box_valid_q;
	assign box        = box_q;

endmodule

@@ hw/rtl/cpbb_checker.sv @@
// port-level checks for cubic_path_bounding_box, attached by bind
// depends on cpbb_pkg
module cpbb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input cpbb_pkg::item_t  item,
	input logic             box_valid,
	input logic             box_ready,
	input cpbb_pkg::box_t   box
);

	// stalled box holds
	a_box_hold: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box_ready |=> box_valid && $stable(box))
		else $error("box changed while stalled");

	// path end always takes the block out of idle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.last |=> !item_ready)
		else $error("ready right after last item");

	// box appears only out of the emit step
	a_box_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(box_valid) |-> !$past(item_ready))
		else $error("box appeared while idle");

	// block is back to idle when a box appears
	a_box_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(box_valid) |-> item_ready)
		else $error("not idle after emit");

endmodule

bind cubic_path_bounding_box cpbb_checker u_cpbb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.item       (item),
	.box_valid  (box_valid),
	.box_ready  (box_ready),
	.box        (box)
);
